// ----- src/rsa_modular_exponentiation_assert.svh -----
// Assertion macros for the modular exponentiation block.
// Expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef RSA_MODULAR_EXPONENTIATION_ASSERT_SVH
`define RSA_MODULAR_EXPONENTIATION_ASSERT_SVH

// Same-cycle implication.
`define RSA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsa: implication check failed");

// Next-cycle implication.
`define RSA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsa: next-cycle check failed");

`endif

// ----- src/rsa_pkg.sv -----
// Shared types and constants for the modular exponentiation block.
// No dependencies.
`timescale 1ns / 1ps
package rsa_pkg;

	localparam int WORD_BITS = 32;
	localparam int CNT_BITS  = $clog2(WORD_BITS);
	localparam int ADDR_BITS = 4;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [1:0] {
		REG_MODULUS     = 2'd0,
		REG_PUBLIC_EXP  = 2'd1,
		REG_PRIVATE_EXP = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

endpackage

// ----- src/rsa_mod_mul.sv -----
// Bit-serial modular multiplier: one multiplier bit per cycle, top bit first.
// Depends on rsa_pkg.
`timescale 1ns / 1ps
module rsa_mod_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rsa_pkg::word_t op_a,
	input  rsa_pkg::word_t op_b,
	input  rsa_pkg::word_t modulus,
	output rsa_pkg::word_t res,
	output rsa_pkg::mm_stat_t stat
);
	import rsa_pkg::*;

	word_t               a_q;
	word_t               b_q;
	word_t               r_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	word_t               r_dbl;
	word_t               r_nxt;

	function automatic word_t add_mod(input word_t x, input word_t y, input word_t n);
		logic [WORD_BITS:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, n})
			s = s - {1'b0, n};
		return s[WORD_BITS-1:0];
	endfunction

	always_comb begin
		r_dbl = add_mod(r_q, r_q, modulus);
		r_nxt = b_q[WORD_BITS-1] ? add_mod(r_dbl, a_q, modulus) : r_dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			r_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= op_a;
				b_q    <= op_b;
				r_q    <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				r_q   <= r_nxt;
				b_q   <= {b_q[WORD_BITS-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(WORD_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res       = r_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- src/rsa_modular_exponentiation.sv -----
// Channel  | Dir | Handshake        | Payload
// s_*      | in  | s_tvalid/tready  | tdata message, tuser req_type
// m_*      | out | m_tvalid/tready  | tdata result
// APB      | in  | psel/penable     | modulus, public and private exponents
//
// Each item runs a chain of modular multiplies: one reduction of the message,
// then a multiply for each set exponent bit and a square for each bit below the
// highest set bit. All of them run on the single bit-serial multiplier.
// s_tready is high only while idle; a finished result waits in the output register
// and the next item is taken meanwhile. Reset clears keys (modulus to 1) and control.
// Depends on rsa_pkg, rsa_mod_mul and the assertion header.
`timescale 1ns / 1ps
module rsa_modular_exponentiation (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [31:0]                  s_tdata,  // [31:0] message
	input  logic                         s_tuser,  // [0] req_type
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata,  // [31:0] result
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rsa_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import rsa_pkg::*;

	`include "rsa_modular_exponentiation_assert.svh"

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_REDUCE  = 5'b00010,
		ST_MUL_ACC = 5'b00100,
		ST_SQUARE  = 5'b01000,
		ST_DONE    = 5'b10000
	} state_t;

	state_t   st_q;
	word_t    mod_q;
	word_t    pub_q;
	word_t    priv_q;
	word_t    exp_q;
	word_t    acc_q;
	word_t    base_q;
	word_t    op_a_q;
	word_t    op_b_q;
	logic     mm_start_q;
	logic     out_valid_q;
	word_t    out_data_q;
	word_t    mm_res;
	mm_stat_t mm_stat;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	assign pready   = 1'b1;
	assign reg_idx  = reg_idx_t'(paddr[3:2]);
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		case (reg_idx)
			REG_MODULUS:     prdata = mod_q;
			REG_PUBLIC_EXP:  prdata = pub_q;
			REG_PRIVATE_EXP: prdata = priv_q;
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= word_t'(1);
			pub_q  <= '0;
			priv_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_MODULUS:     mod_q  <= pwdata;
				REG_PUBLIC_EXP:  pub_q  <= pwdata;
				REG_PRIVATE_EXP: priv_q <= pwdata;
				default:         ;
			endcase
		end
	end

	rsa_mod_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start_q),
		.op_a    (op_a_q),
		.op_b    (op_b_q),
		.modulus (mod_q),
		.res     (mm_res),
		.stat    (mm_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			exp_q       <= '0;
			acc_q       <= '0;
			base_q      <= '0;
			op_a_q      <= '0;
			op_b_q      <= '0;
			mm_start_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (mm_start_q)
				mm_start_q <= 1'b0;
			if (m_tready && (st_q != ST_DONE))
				out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						exp_q <= s_tuser ? priv_q : pub_q;
						if (mod_q <= word_t'(1)) begin
							acc_q <= '0;
							st_q  <= ST_DONE;
						end else begin
							acc_q      <= word_t'(1);
							op_a_q     <= word_t'(1);
							op_b_q     <= s_tdata;
							mm_start_q <= 1'b1;
							st_q       <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					if (mm_stat.done) begin
						base_q <= mm_res;
						if (exp_q == '0) begin
							st_q <= ST_DONE;
						end else if (exp_q[0]) begin
							op_a_q     <= acc_q;
							op_b_q     <= mm_res;
							mm_start_q <= 1'b1;
							st_q       <= ST_MUL_ACC;
						end else begin
							op_a_q     <= mm_res;
							op_b_q     <= mm_res;
							mm_start_q <= 1'b1;
							st_q       <= ST_SQUARE;
						end
					end
				end
				ST_MUL_ACC: begin
					if (mm_stat.done) begin
						acc_q <= mm_res;
						if (exp_q[WORD_BITS-1:1] == '0) begin
							st_q <= ST_DONE;
						end else begin
							op_a_q     <= base_q;
							op_b_q     <= base_q;
							mm_start_q <= 1'b1;
							st_q       <= ST_SQUARE;
						end
					end
				end
				ST_SQUARE: begin
					if (mm_stat.done) begin
						base_q     <= mm_res;
						exp_q      <= {1'b0, exp_q[WORD_BITS-1:1]};
						mm_start_q <= 1'b1;
						if (exp_q[1]) begin
							op_a_q <= acc_q;
							op_b_q <= mm_res;
							st_q   <= ST_MUL_ACC;
						end else begin
							op_a_q <= mm_res;
							op_b_q <= mm_res;
							st_q   <= ST_SQUARE;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= acc_q;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`RSA_ASSERT_IMP(a_mul_busy_in_mul_state, mm_stat.busy,
		st_q == ST_REDUCE || st_q == ST_MUL_ACC || st_q == ST_SQUARE)
	`RSA_ASSERT_NXT(a_accept_leaves_idle, s_tvalid && s_tready, st_q != ST_IDLE)
	`RSA_ASSERT_IMP(a_result_below_modulus, m_tvalid && (mod_q > word_t'(1)), m_tdata < mod_q)
	`RSA_ASSERT_IMP(a_start_when_free, mm_start_q, !mm_stat.busy)

endmodule
